>>> rtl/qrpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpf_pkg
// Shared widths, register indexes and payload types for the quadrilateral
// region point filter.
// ----------------------------------------------------------------------------
package qrpf_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int FRAC_BITS       = 8;
    localparam int INTENSITY_WIDTH = 16;
    localparam int NUM_CORNER_REGS = 8;
    localparam int REG_INDEX_WIDTH = $clog2(NUM_CORNER_REGS);

    // height limit: 1.0 m in Q15.8
    localparam int Z_LIMIT = 1 << FRAC_BITS;

    // widths of the exact area arithmetic
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int AREA_WIDTH  = CROSS_WIDTH;
    localparam int SUM_WIDTH   = AREA_WIDTH + 2;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_CORNER_A_X,
        REG_CORNER_A_Y,
        REG_CORNER_B_X,
        REG_CORNER_B_Y,
        REG_CORNER_C_X,
        REG_CORNER_C_Y,
        REG_CORNER_D_X,
        REG_CORNER_D_Y
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } vec_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]   point_x;
        logic signed [COORD_WIDTH-1:0]   point_y;
        logic signed [COORD_WIDTH-1:0]   point_z;
        logic        [INTENSITY_WIDTH-1:0] point_intensity;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]   kept_x;
        logic signed [COORD_WIDTH-1:0]   kept_y;
        logic signed [COORD_WIDTH-1:0]   kept_z;
        logic        [INTENSITY_WIDTH-1:0] kept_intensity;
    } kept_t;

endpackage
`default_nettype wire

>>> rtl/qrpf_tri_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpf_tri_test
// Exact point-in-triangle test: doubled triangle area against the sum of the
// three sub-triangle areas. Products are registered; the compare follows.
// ----------------------------------------------------------------------------
module qrpf_tri_test (
    input  wire logic          clk,
    input  wire qrpf_pkg::vec_t corner_a,
    input  wire qrpf_pkg::vec_t corner_b,
    input  wire qrpf_pkg::vec_t corner_c,
    input  wire qrpf_pkg::vec_t pt,
    output logic               hit
);

    localparam int W = qrpf_pkg::COORD_WIDTH;

    typedef logic signed [qrpf_pkg::DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [qrpf_pkg::PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [qrpf_pkg::CROSS_WIDTH-1:0] cross_t;
    typedef logic        [qrpf_pkg::AREA_WIDTH-1:0]  area_t;
    typedef logic        [qrpf_pkg::SUM_WIDTH-1:0]   sum_t;

    diff_t ab_x, ab_y, ac_x, ac_y, ap_x, ap_y;
    diff_t pb_x, pb_y, pc_x, pc_y;
    prod_t prod_next [8];
    prod_t prod_reg  [8];
    area_t area_whole, area_pbc, area_apc, area_abp;
    sum_t  area_sum;

    function automatic area_t area_of(prod_t t1, prod_t t2);
        cross_t c;
        c = {t1[qrpf_pkg::PROD_WIDTH-1], t1} - {t2[qrpf_pkg::PROD_WIDTH-1], t2};
        return c[qrpf_pkg::CROSS_WIDTH-1] ? area_t'(-c) : area_t'(c);
    endfunction

    always_comb
    begin
        ab_x = {corner_b.x[W-1], corner_b.x} - {corner_a.x[W-1], corner_a.x};
        ab_y = {corner_b.y[W-1], corner_b.y} - {corner_a.y[W-1], corner_a.y};
        ac_x = {corner_c.x[W-1], corner_c.x} - {corner_a.x[W-1], corner_a.x};
        ac_y = {corner_c.y[W-1], corner_c.y} - {corner_a.y[W-1], corner_a.y};
        ap_x = {pt.x[W-1], pt.x} - {corner_a.x[W-1], corner_a.x};
        ap_y = {pt.y[W-1], pt.y} - {corner_a.y[W-1], corner_a.y};
        pb_x = {corner_b.x[W-1], corner_b.x} - {pt.x[W-1], pt.x};
        pb_y = {corner_b.y[W-1], corner_b.y} - {pt.y[W-1], pt.y};
        pc_x = {corner_c.x[W-1], corner_c.x} - {pt.x[W-1], pt.x};
        pc_y = {corner_c.y[W-1], corner_c.y} - {pt.y[W-1], pt.y};

        // product terms of the cross product of each triangle's edge vectors
        prod_next[0] = ab_x * ac_y;
        prod_next[1] = ac_x * ab_y;
        prod_next[2] = pb_x * pc_y;
        prod_next[3] = pc_x * pb_y;
        prod_next[4] = ap_x * ac_y;
        prod_next[5] = ac_x * ap_y;
        prod_next[6] = ab_x * ap_y;
        prod_next[7] = ap_x * ab_y;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_comb
    begin
        area_whole = area_of(prod_reg[0], prod_reg[1]);
        area_pbc   = area_of(prod_reg[2], prod_reg[3]);
        area_apc   = area_of(prod_reg[4], prod_reg[5]);
        area_abp   = area_of(prod_reg[6], prod_reg[7]);
        area_sum   = sum_t'(area_pbc) + sum_t'(area_apc) + sum_t'(area_abp);
        hit        = (sum_t'(area_whole) == area_sum);
    end

endmodule
`default_nettype wire

>>> rtl/quad_region_point_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_region_point_filter
// Passes a lidar point when (x, y) lies in a configured quadrilateral and
// z is below 1.0 m; drops it otherwise.
// ----------------------------------------------------------------------------
// A request is taken on every clock where start is high; busy stays low, so
// one point per cycle is sustained. A kept point appears on result with
// result_valid high for exactly one cycle, after the input register, the
// product register and the result register; a dropped point gives no strobe.
// The receiver cannot stall the output. The user must write corners through
// write_enable/reg_index/write_data only while no points are in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module quad_region_point_filter (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    output logic                                          busy,
    input  wire qrpf_pkg::point_t                          point,
    input  wire logic                                     write_enable,
    input  wire logic [qrpf_pkg::REG_INDEX_WIDTH-1:0]     reg_index,
    input  wire logic [qrpf_pkg::COORD_WIDTH-1:0]         write_data,
    output logic                                          result_valid,
    output qrpf_pkg::kept_t                                result
);

    qrpf_pkg::vec_t   corner_a_reg, corner_b_reg, corner_c_reg, corner_d_reg;
    qrpf_pkg::point_t point1_reg, point2_reg;
    qrpf_pkg::vec_t   pt1;
    qrpf_pkg::kept_t  result_next;
    logic             valid1_reg, valid2_reg, z_ok2_reg;
    logic             in_abc, in_adc;
    logic             result_valid_next;
    logic             z_ok1;

    assign busy = 1'b0;

    // corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_a_reg <= '0;
            corner_b_reg <= '0;
            corner_c_reg <= '0;
            corner_d_reg <= '0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                qrpf_pkg::REG_CORNER_A_X: corner_a_reg.x <= write_data;
                qrpf_pkg::REG_CORNER_A_Y: corner_a_reg.y <= write_data;
                qrpf_pkg::REG_CORNER_B_X: corner_b_reg.x <= write_data;
                qrpf_pkg::REG_CORNER_B_Y: corner_b_reg.y <= write_data;
                qrpf_pkg::REG_CORNER_C_X: corner_c_reg.x <= write_data;
                qrpf_pkg::REG_CORNER_C_Y: corner_c_reg.y <= write_data;
                qrpf_pkg::REG_CORNER_D_X: corner_d_reg.x <= write_data;
                qrpf_pkg::REG_CORNER_D_Y: corner_d_reg.y <= write_data;
                default: ;
            endcase
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg   <= 1'b0;
            valid2_reg   <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            valid1_reg   <= start && !busy;
            valid2_reg   <= valid1_reg;
            result_valid <= result_valid_next;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        point1_reg <= point;
        point2_reg <= point1_reg;
        z_ok2_reg  <= z_ok1;
        result     <= result_next;
    end

    always_comb
    begin
        pt1.x = point1_reg.point_x;
        pt1.y = point1_reg.point_y;
        z_ok1 = (point1_reg.point_z < qrpf_pkg::Z_LIMIT);
    end

    // the quadrilateral is the union of triangles (a, b, c) and (a, d, c)
    qrpf_tri_test u_tri_abc (
        .clk      (clk),
        .corner_a (corner_a_reg),
        .corner_b (corner_b_reg),
        .corner_c (corner_c_reg),
        .pt       (pt1),
        .hit      (in_abc)
    );

    qrpf_tri_test u_tri_adc (
        .clk      (clk),
        .corner_a (corner_a_reg),
        .corner_b (corner_d_reg),
        .corner_c (corner_c_reg),
        .pt       (pt1),
        .hit      (in_adc)
    );

    always_comb
    begin
        result_valid_next          = valid2_reg && z_ok2_reg && (in_abc || in_adc);
        result_next.kept_x         = point2_reg.point_x;
        result_next.kept_y         = point2_reg.point_y;
        result_next.kept_z         = point2_reg.point_z;
        result_next.kept_intensity = point2_reg.point_intensity;
    end

    a_result_follows_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 3)
    ) else $error("result strobe without a request three cycles earlier");

    a_result_height: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kept_z < qrpf_pkg::Z_LIMIT)
    ) else $error("kept point at or above the height limit");

    a_result_payload: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kept_x == $past(point.point_x, 3)
                          && result.kept_intensity == $past(point.point_intensity, 3))
    ) else $error("kept point does not match its request");

endmodule
`default_nettype wire

>>> bench/tb_quad_region_point_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_region_point_filter
// Streams lidar points into the quadrilateral region filter and checks every
// strobed result against a local predictor built on exact doubled triangle
// areas. A short directed table covers field extremes, boundary points and
// degenerate, crossed and full-range regions; random phases follow, each with
// a fresh region and one of three idle patterns on the request side.
// ----------------------------------------------------------------------------
module tb_quad_region_point_filter;

    localparam int COORD_W         = qrpf_pkg::COORD_WIDTH;
    localparam int INTENSITY_W     = qrpf_pkg::INTENSITY_WIDTH;
    localparam int LATENCY         = 3;
    localparam int DRAIN_LIMIT     = 64;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int C_MIN           = -(1 << (COORD_W - 1));
    localparam int C_MAX           = (1 << (COORD_W - 1)) - 1;
    localparam int AREA_W          = 2 * COORD_W + 8;

    typedef logic signed [AREA_W-1:0] area_t;

    typedef struct packed {
        qrpf_pkg::vec_t a;
        qrpf_pkg::vec_t b;
        qrpf_pkg::vec_t c;
        qrpf_pkg::vec_t d;
    } quad_t;

    typedef enum {OUT_PREDICTED, OUT_KEPT, OUT_DROPPED} verdict_t;

    typedef struct {
        int               quad_sel;
        qrpf_pkg::point_t pt;
        verdict_t         verdict;
    } directed_row_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    qrpf_pkg::point_t                       point;
    logic                                   write_enable;
    logic [qrpf_pkg::REG_INDEX_WIDTH-1:0]   reg_index;
    logic [COORD_W-1:0]                     write_data;
    logic                                   result_valid;
    qrpf_pkg::kept_t                        result;

    quad_t           region;
    quad_t           quad_set [5];
    directed_row_t   directed_rows [$];
    qrpf_pkg::kept_t kept_queue [$];
    int              mismatches = 0;
    int              cycle_count = 0;

    quad_region_point_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point        (point),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic area_t doubled_area(qrpf_pkg::vec_t p, qrpf_pkg::vec_t q,
                                           qrpf_pkg::vec_t r);
        area_t px, py, qx, qy, rx, ry, cp;
        px = p.x;
        py = p.y;
        qx = q.x;
        qy = q.y;
        rx = r.x;
        ry = r.y;
        cp = (qx - px) * (ry - py) - (rx - px) * (qy - py);
        return (cp < 0) ? -cp : cp;
    endfunction

    function automatic bit in_triangle(qrpf_pkg::vec_t a, qrpf_pkg::vec_t b,
                                       qrpf_pkg::vec_t c, qrpf_pkg::vec_t p);
        return doubled_area(a, b, c) ==
               doubled_area(p, b, c) + doubled_area(a, p, c) + doubled_area(a, b, p);
    endfunction

    function automatic bit point_is_kept(quad_t q, qrpf_pkg::point_t pt);
        qrpf_pkg::vec_t p;
        p.x = pt.point_x;
        p.y = pt.point_y;
        return (in_triangle(q.a, q.b, q.c, p) || in_triangle(q.a, q.d, q.c, p))
               && (pt.point_z < qrpf_pkg::Z_LIMIT);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic quad_t make_quad(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
        quad_t q;
        q.a.x = COORD_W'(ax);
        q.a.y = COORD_W'(ay);
        q.b.x = COORD_W'(bx);
        q.b.y = COORD_W'(by);
        q.c.x = COORD_W'(cx);
        q.c.y = COORD_W'(cy);
        q.d.x = COORD_W'(dx);
        q.d.y = COORD_W'(dy);
        return q;
    endfunction

    function automatic quad_t make_region(int shape);
        int v [8];
        int cx, cy, dx, dy, r, k;
        cx = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        cy = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        dx = int'($urandom_range(0, 512)) - 256;
        dy = int'($urandom_range(0, 512)) - 256;
        r  = $urandom_range(8, 4096);
        for (int i = 0; i < 4; i++)
        begin
            k = $urandom_range(0, 3);
            case (shape)
                0:
                begin
                    v[2*i]   = $urandom_range(0, 1) ? C_MAX : C_MIN;
                    v[2*i+1] = $urandom_range(0, 1) ? C_MAX : C_MIN;
                end
                // collinear corners
                1:
                begin
                    v[2*i]   = cx + k * dx;
                    v[2*i+1] = cy + k * dy;
                end
                default:
                begin
                    v[2*i]   = cx * 7 + int'($urandom_range(0, 2 * r)) - r;
                    v[2*i+1] = cy * 7 + int'($urandom_range(0, 2 * r)) - r;
                end
            endcase
        end
        return make_quad(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    function automatic qrpf_pkg::point_t random_point(quad_t q);
        qrpf_pkg::point_t pt;
        int xs [4];
        int ys [4];
        int lo_x, hi_x, lo_y, hi_y, pick, k, j;
        xs = '{q.a.x, q.b.x, q.c.x, q.d.x};
        ys = '{q.a.y, q.b.y, q.c.y, q.d.y};
        lo_x = xs[0];
        hi_x = xs[0];
        lo_y = ys[0];
        hi_y = ys[0];
        for (int i = 1; i < 4; i++)
        begin
            if (xs[i] < lo_x) lo_x = xs[i];
            if (xs[i] > hi_x) hi_x = xs[i];
            if (ys[i] < lo_y) lo_y = ys[i];
            if (ys[i] > hi_y) hi_y = ys[i];
        end
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            // bounding box, slightly widened to reach just outside the edges
            pt.point_x = COORD_W'(lo_x - 2 + int'($urandom_range(0, hi_x - lo_x + 4)));
            pt.point_y = COORD_W'(lo_y - 2 + int'($urandom_range(0, hi_y - lo_y + 4)));
        end
        else if (pick < 75)
        begin
            k = $urandom_range(0, 3);
            j = (k + 1) % 4;
            if ($urandom_range(0, 1))
            begin
                pt.point_x = COORD_W'(xs[k]);
                pt.point_y = COORD_W'(ys[k]);
            end
            else
            begin
                pt.point_x = COORD_W'((longint'(xs[k]) + xs[j]) >>> 1);
                pt.point_y = COORD_W'((longint'(ys[k]) + ys[j]) >>> 1);
            end
        end
        else
        begin
            pt.point_x = COORD_W'($urandom);
            pt.point_y = COORD_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
            pt.point_z = COORD_W'(int'($urandom_range(0, 767)) - 512);
        else if (pick < 85)
            pt.point_z = COORD_W'(qrpf_pkg::Z_LIMIT - 4 + int'($urandom_range(0, 8)));
        else
            pt.point_z = COORD_W'($urandom);
        pt.point_intensity = INTENSITY_W'($urandom);
        return pt;
    endfunction

    task automatic add_row(int sel, int x, int y, int z, int intensity, verdict_t verdict);
        directed_row_t row;
        row.quad_sel              = sel;
        row.pt.point_x            = COORD_W'(x);
        row.pt.point_y            = COORD_W'(y);
        row.pt.point_z            = COORD_W'(z);
        row.pt.point_intensity    = INTENSITY_W'(intensity);
        row.verdict               = verdict;
        directed_rows.push_back(row);
    endtask

    // Call right after posedge clk with no request in flight.
    task automatic program_region(quad_t q);
        logic [COORD_W-1:0] vals [qrpf_pkg::NUM_CORNER_REGS];
        vals = '{q.a.x, q.a.y, q.b.x, q.b.y, q.c.x, q.c.y, q.d.x, q.d.y};
        for (int i = 0; i < qrpf_pkg::NUM_CORNER_REGS; i++)
        begin
            write_enable <= 1'b1;
            reg_index    <= qrpf_pkg::reg_index_t'(i);
            write_data   <= vals[i];
            @(posedge clk);
        end
        write_enable <= 1'b0;
        region = q;
    endtask

    task automatic send_point(qrpf_pkg::point_t pt, verdict_t verdict);
        qrpf_pkg::kept_t k;
        bit              keep;
        start <= 1'b1;
        point <= pt;
        do
            @(posedge clk);
        while (busy);
        case (verdict)
            OUT_PREDICTED: keep = point_is_kept(region, pt);
            OUT_KEPT:      keep = 1'b1;
            default:       keep = 1'b0;
        endcase
        if (keep)
        begin
            k.kept_x         = pt.point_x;
            k.kept_y         = pt.point_y;
            k.kept_z         = pt.point_z;
            k.kept_intensity = pt.point_intensity;
            kept_queue.push_back(k);
        end
    endtask

    // Hold requests off until every kept point has come out or the drain limit
    // runs out, then let dropped points drain through the pipeline as well.
    task automatic settle();
        int waited;
        start <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (kept_queue.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (kept_queue.size() != 0)
        begin
            $display("%0t: %0d kept points never came out, oldest expected x=%0d y=%0d",
                     $time, kept_queue.size(), kept_queue[0].kept_x, kept_queue[0].kept_y);
            mismatches += kept_queue.size();
            kept_queue.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        qrpf_pkg::kept_t want;
        if (rst_n && result_valid)
        begin
            if (kept_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got x=%0d y=%0d z=%0d i=%0h",
                         $time, result.kept_x, result.kept_y, result.kept_z,
                         result.kept_intensity);
                mismatches++;
            end
            else
            begin
                want = kept_queue.pop_front();
                if (result.kept_x !== want.kept_x)
                begin
                    $display("%0t: kept_x expected %0d got %0d",
                             $time, want.kept_x, result.kept_x);
                    mismatches++;
                end
                if (result.kept_y !== want.kept_y)
                begin
                    $display("%0t: kept_y expected %0d got %0d",
                             $time, want.kept_y, result.kept_y);
                    mismatches++;
                end
                if (result.kept_z !== want.kept_z)
                begin
                    $display("%0t: kept_z expected %0d got %0d",
                             $time, want.kept_z, result.kept_z);
                    mismatches++;
                end
                if (result.kept_intensity !== want.kept_intensity)
                begin
                    $display("%0t: kept_intensity expected %0h got %0h",
                             $time, want.kept_intensity, result.kept_intensity);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int               cur_sel;
        int               idle_pct;
        int               shape;
        qrpf_pkg::point_t pt;

        rst_n        = 1'b0;
        start        = 1'b0;
        point        = '0;
        write_enable = 1'b0;
        reg_index    = qrpf_pkg::REG_CORNER_A_X;
        write_data   = '0;
        region       = '0;

        quad_set[0] = '0;
        quad_set[1] = make_quad(0, 0, 1024, 0, 1024, 1024, 0, 1024);
        quad_set[2] = make_quad(0, 0, 256, 256, 512, 512, 512, 512);
        quad_set[3] = make_quad(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX);
        quad_set[4] = make_quad(0, 0, 1024, 1024, 1024, 0, 0, 1024);

        // all corners at the origin after reset: only the height decides
        add_row(0, 0, 0, 0, 0, OUT_KEPT);
        add_row(0, C_MAX, C_MAX, qrpf_pkg::Z_LIMIT - 1, 16'hffff, OUT_KEPT);
        add_row(0, C_MIN, C_MIN, qrpf_pkg::Z_LIMIT, 16'h0000, OUT_DROPPED);
        add_row(0, C_MAX, C_MIN, C_MIN, 16'h1234, OUT_KEPT);
        add_row(0, C_MIN, C_MAX, C_MAX, 16'h8000, OUT_DROPPED);
        add_row(0, -1, -1, -1, 16'h5555, OUT_KEPT);
        // square: interior, corners, edges, split diagonal, just outside, height limit
        add_row(1, 512, 512, 0, 16'h0001, OUT_PREDICTED);
        add_row(1, 0, 0, qrpf_pkg::Z_LIMIT - 1, 16'h0002, OUT_PREDICTED);
        add_row(1, 1024, 1024, -256, 16'h0003, OUT_PREDICTED);
        add_row(1, 1024, 0, 0, 16'h0004, OUT_PREDICTED);
        add_row(1, 512, 0, 0, 16'h0005, OUT_PREDICTED);
        add_row(1, 300, 300, 0, 16'h0006, OUT_PREDICTED);
        add_row(1, 1025, 512, 0, 16'h0007, OUT_PREDICTED);
        add_row(1, -1, 512, 0, 16'h0008, OUT_PREDICTED);
        add_row(1, 512, 512, qrpf_pkg::Z_LIMIT, 16'h0009, OUT_PREDICTED);
        // collinear corners: on the line, off it, beyond the segment
        add_row(2, 128, 128, 0, 16'h00a0, OUT_PREDICTED);
        add_row(2, 128, 129, 0, 16'h00a1, OUT_PREDICTED);
        add_row(2, 600, 600, 0, 16'h00a2, OUT_PREDICTED);
        // full-range region
        add_row(3, C_MIN, C_MIN, 0, 16'h0b00, OUT_PREDICTED);
        add_row(3, C_MAX, C_MAX, 0, 16'h0b01, OUT_PREDICTED);
        add_row(3, C_MIN, C_MAX, C_MIN, 16'h0b02, OUT_PREDICTED);
        // crossed corners
        add_row(4, 900, 300, 0, 16'h0c00, OUT_PREDICTED);
        add_row(4, 100, 700, 0, 16'h0c01, OUT_PREDICTED);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_sel = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].quad_sel != cur_sel)
            begin
                settle();
                cur_sel = directed_rows[i].quad_sel;
                program_region(quad_set[cur_sel]);
            end
            send_point(directed_rows[i].pt, directed_rows[i].verdict);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            if (ph < 2)
                shape = ph;
            else
                shape = $urandom_range(0, 9);
            program_region(make_region(shape));
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 54;
                default: idle_pct = 29;
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                pt = random_point(region);
                send_point(pt, OUT_PREDICTED);
                if (int'($urandom_range(0, 99)) < idle_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/qrpf_pkg.sv
rtl/qrpf_tri_test.sv
rtl/quad_region_point_filter.sv
bench/tb_quad_region_point_filter.sv
